// ===== hw/rtl/lpc_pkg.sv =====
package lpc_pkg;

	localparam int POS_W = 32;
	localparam int ANG_W = 16;
	localparam int ID_W = 16;
	localparam int VEC_W = 34;
	localparam int GUARD = 6;
	localparam int CFG_IDX_W = 3;
	localparam int QDEPTH = 4;
	localparam int SUM_W = 37;
	localparam logic signed [21:0] GAIN = 22'sd1273502;

	localparam logic [CFG_IDX_W-1:0] CFG_QR_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QR_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QR_ANGLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIDAR_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LIDAR_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LIDAR_ANGLE = 3'd5;

	typedef struct packed {
		logic [ID_W-1:0] base_mark_id;
		logic signed [POS_W-1:0] base_mark_x;
		logic signed [POS_W-1:0] base_mark_y;
		logic signed [ANG_W-1:0] base_mark_angle;
		logic [ID_W-1:0] cur_mark_id;
		logic signed [POS_W-1:0] cur_mark_x;
		logic signed [POS_W-1:0] cur_mark_y;
		logic signed [ANG_W-1:0] cur_mark_angle;
		logic signed [POS_W-1:0] base_pose_x;
		logic signed [POS_W-1:0] base_pose_y;
		logic signed [ANG_W-1:0] base_pose_heading;
	} in_item_t;

	typedef struct packed {
		logic matched;
		logic signed [POS_W-1:0] out_x;
		logic signed [POS_W-1:0] out_y;
		logic signed [ANG_W-1:0] out_heading;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [POS_W-1:0] value;
	} cfg_item_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic signed [ANG_W-1:0] ang;
	} lane_in_t;

	typedef struct packed {
		logic matched;
		logic signed [ANG_W-1:0] heading;
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
	} side_t;

	typedef struct packed {
		side_t side;
		lane_in_t [2:0] lane;
	} work_t;

	typedef struct packed {
		logic [$clog2(QDEPTH+1)-1:0] cnt;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic neg;
		logic signed [ANG_W-1:0] ang;
	} fold_t;

	function automatic fold_t fold_angle(input logic signed [ANG_W-1:0] a);
		fold_t f;
		f.neg = 1'b0;
		f.ang = a;
		if (a > 16'sd16384) begin
			f.neg = 1'b1;
			f.ang = a - 16'sh8000;
		end else if (a < -16'sd16384) begin
			f.neg = 1'b1;
			f.ang = a + 16'sh8000;
		end
		return f;
	endfunction

	function automatic logic [31:0] atan_val(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'h20000000;
			1: r = 32'h12E4051E;
			2: r = 32'h09FB385B;
			3: r = 32'h051111D4;
			4: r = 32'h028B0D43;
			5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;
			7: r = 32'h00517C55;
			8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/lpc_chan_if.sv =====
interface lpc_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/landmark_pose_composer_unit.sv =====
// Landmark pose composer.
// pose_in carries one beat per landmark pair: both sightings with their ids
// and the lidar pose of the base scan. pose_out returns one beat per input
// beat, in order: matched, the derived lidar x/y (Q16.16, saturated) and the
// wrapped heading. Mismatched ids give matched low and zero fields.
// cfg writes the code reader and lidar mount registers by index; it is always
// ready and should be used only while no beat is in flight.
// Throughput is one beat per cycle while pose_out does not stall. After its
// input beat is accepted into the queue, a beat passes through the CORDIC
// load stage that pops the queue, CORDIC_STAGES rotation stages, the gain
// multiply stage, the rounding stage and the summing output register.
// When pose_out stalls, the whole back pipeline holds; the 4-beat queue keeps
// accepting until full, then pose_in.ready drops.
// Reset clears the mount registers to zero and empties queue and pipeline.
module landmark_pose_composer_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	lpc_chan_if.sink pose_in,
	lpc_chan_if.source pose_out,
	lpc_chan_if.sink cfg
);

	logic push, adv, q_valid;
	lpc_pkg::work_t push_data, q_data;
	lpc_pkg::q_stat_t q_stat;

	lpc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pose_in(pose_in),
		.cfg(cfg),
		.q_stat(q_stat),
		.push(push),
		.push_data(push_data)
	);

	lpc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.adv(adv),
		.pop_valid(q_valid),
		.pop_data(q_data),
		.q_stat(q_stat)
	);

	lpc_back #(.STAGES(CORDIC_STAGES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_data(q_data),
		.adv(adv),
		.pose_out(pose_out)
	);

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pose_in.ready |-> q_stat.cnt == 3'(lpc_pkg::QDEPTH))
		else $error("input stalled with queue not full");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.cnt <= 3'(lpc_pkg::QDEPTH))
		else $error("queue overfilled");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full && !adv |=> q_stat.full)
		else $error("full queue drained without back advance");

	a_mismatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pose_out.valid && !pose_out.data.matched |->
		pose_out.data.out_x == 0 && pose_out.data.out_y == 0 &&
		pose_out.data.out_heading == 0)
		else $error("mismatched beat carries data");

endmodule

// ===== hw/rtl/lpc_front.sv =====
module lpc_front (
	input  logic clk,
	input  logic arst_n,
	lpc_chan_if.sink pose_in,
	lpc_chan_if.sink cfg,
	input  lpc_pkg::q_stat_t q_stat,
	output logic push,
	output lpc_pkg::work_t push_data
);

	logic signed [lpc_pkg::POS_W-1:0] qx_q, qy_q, lx_q, ly_q;
	logic signed [lpc_pkg::ANG_W-1:0] qa_q, la_q;
	lpc_pkg::in_item_t it;
	logic signed [lpc_pkg::ANG_W-1:0] ang1, ang2, ang3;
	logic signed [lpc_pkg::VEC_W-1:0] dqx, dqy, dcx, dcy;
	lpc_pkg::fold_t f1, f2, f3;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= '0;
			qy_q <= '0;
			qa_q <= '0;
			lx_q <= '0;
			ly_q <= '0;
			la_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				lpc_pkg::CFG_QR_X: qx_q <= cfg.data.value;
				lpc_pkg::CFG_QR_Y: qy_q <= cfg.data.value;
				lpc_pkg::CFG_QR_ANGLE: qa_q <= cfg.data.value[lpc_pkg::ANG_W-1:0];
				lpc_pkg::CFG_LIDAR_X: lx_q <= cfg.data.value;
				lpc_pkg::CFG_LIDAR_Y: ly_q <= cfg.data.value;
				lpc_pkg::CFG_LIDAR_ANGLE: la_q <= cfg.data.value[lpc_pkg::ANG_W-1:0];
				default: ;
			endcase
		end
	end

	assign it = pose_in.data;
	assign pose_in.ready = !q_stat.full;
	assign push = pose_in.valid && !q_stat.full;

	always_comb begin
		ang1 = it.base_pose_heading - la_q;
		ang2 = ang1 + qa_q - it.base_mark_angle;
		ang3 = ang1 - it.base_mark_angle + it.cur_mark_angle;
		dqx = lpc_pkg::VEC_W'(qx_q) - lpc_pkg::VEC_W'(lx_q);
		dqy = lpc_pkg::VEC_W'(qy_q) - lpc_pkg::VEC_W'(ly_q);
		dcx = lpc_pkg::VEC_W'(it.cur_mark_x) - lpc_pkg::VEC_W'(it.base_mark_x);
		dcy = lpc_pkg::VEC_W'(it.cur_mark_y) - lpc_pkg::VEC_W'(it.base_mark_y);
		f1 = lpc_pkg::fold_angle(ang1);
		f2 = lpc_pkg::fold_angle(ang2);
		f3 = lpc_pkg::fold_angle(ang3);

		push_data.side.matched = (it.base_mark_id == it.cur_mark_id);
		push_data.side.heading = it.base_pose_heading + it.cur_mark_angle
			- it.base_mark_angle;
		push_data.side.px = it.base_pose_x;
		push_data.side.py = it.base_pose_y;

		push_data.lane[0].vx = f1.neg ? -dqx : dqx;
		push_data.lane[0].vy = f1.neg ? -dqy : dqy;
		push_data.lane[0].ang = f1.ang;
		push_data.lane[1].vx = f2.neg ? -dcx : dcx;
		push_data.lane[1].vy = f2.neg ? -dcy : dcy;
		push_data.lane[1].ang = f2.ang;
		push_data.lane[2].vx = f3.neg ? dqx : -dqx;
		push_data.lane[2].vy = f3.neg ? dqy : -dqy;
		push_data.lane[2].ang = f3.ang;
	end

endmodule

// ===== hw/rtl/lpc_queue.sv =====
module lpc_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  lpc_pkg::work_t push_data,
	input  logic adv,
	output logic pop_valid,
	output lpc_pkg::work_t pop_data,
	output lpc_pkg::q_stat_t q_stat
);

	localparam int PW = $clog2(lpc_pkg::QDEPTH);
	localparam int CW = $clog2(lpc_pkg::QDEPTH + 1);

	lpc_pkg::work_t mem_q [0:lpc_pkg::QDEPTH-1];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic pop;

	assign pop_valid = (cnt_q != '0);
	assign pop = adv && pop_valid;
	assign pop_data = mem_q[rd_ptr_q];
	assign q_stat.cnt = cnt_q;
	assign q_stat.full = (cnt_q == CW'(lpc_pkg::QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/lpc_cordic_lane.sv =====
module lpc_cordic_lane #(
	parameter int STAGES = 16
) (
	input  logic clk,
	input  logic en,
	input  lpc_pkg::lane_in_t lin,
	output logic signed [lpc_pkg::VEC_W-1:0] rx,
	output logic signed [lpc_pkg::VEC_W-1:0] ry
);

	localparam int XW = lpc_pkg::VEC_W + lpc_pkg::GUARD + 2;
	localparam int ZW = 34;

	logic signed [XW-1:0] cx_s [0:STAGES];
	logic signed [XW-1:0] cy_s [0:STAGES];
	logic signed [ZW-1:0] cz_s [0:STAGES];
	logic signed [XW-22:0] xh, yh;
	logic signed [21:0] xl, yl;
	logic signed [XW-21+21:0] phx_s, phy_s;
	logic signed [43:0] plx_s, ply_s;
	logic signed [63:0] sx, sy;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= {{2{lin.vx[lpc_pkg::VEC_W-1]}}, lin.vx, {lpc_pkg::GUARD{1'b0}}};
			cy_s[0] <= {{2{lin.vy[lpc_pkg::VEC_W-1]}}, lin.vy, {lpc_pkg::GUARD{1'b0}}};
			cz_s[0] <= {{2{lin.ang[lpc_pkg::ANG_W-1]}}, lin.ang, 16'b0};
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s[i][ZW-1]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - $signed({2'b0, lpc_pkg::atan_val(i)});
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + $signed({2'b0, lpc_pkg::atan_val(i)});
				end
			end
		end
	end

	assign xh = cx_s[STAGES][XW-1:21];
	assign yh = cy_s[STAGES][XW-1:21];
	assign xl = $signed({1'b0, cx_s[STAGES][20:0]});
	assign yl = $signed({1'b0, cy_s[STAGES][20:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			phx_s <= xh * lpc_pkg::GAIN;
			phy_s <= yh * lpc_pkg::GAIN;
			plx_s <= xl * lpc_pkg::GAIN;
			ply_s <= yl * lpc_pkg::GAIN;
		end
	end

	always_comb begin
		sx = (64'(phx_s) <<< 21) + 64'(plx_s) + 64'sd67108864;
		sy = (64'(phy_s) <<< 21) + 64'(ply_s) + 64'sd67108864;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx <= sx[27+lpc_pkg::VEC_W-1:27];
			ry <= sy[27+lpc_pkg::VEC_W-1:27];
		end
	end

endmodule

// ===== hw/rtl/lpc_back.sv =====
module lpc_back #(
	parameter int STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  lpc_pkg::work_t q_data,
	output logic adv,
	lpc_chan_if.source pose_out
);

	localparam int DEPTH = STAGES + 3;
	localparam int SW = lpc_pkg::SUM_W;

	logic [DEPTH-1:0] v_s;
	lpc_pkg::side_t side_s [0:DEPTH-1];
	logic signed [lpc_pkg::VEC_W-1:0] rx [0:2];
	logic signed [lpc_pkg::VEC_W-1:0] ry [0:2];
	logic signed [SW-1:0] sum_x, sum_y;
	logic out_valid_q;
	lpc_pkg::out_item_t out_q;
	lpc_pkg::side_t sd;

	assign adv = !out_valid_q || pose_out.ready;
	assign pose_out.valid = out_valid_q;
	assign pose_out.data = out_q;
	assign sd = side_s[DEPTH-1];

	for (genvar l = 0; l < 3; l++) begin : g_lane
		lpc_cordic_lane #(.STAGES(STAGES)) u_lane (
			.clk(clk),
			.en(adv),
			.lin(q_data.lane[l]),
			.rx(rx[l]),
			.ry(ry[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s <= {v_s[DEPTH-2:0], q_valid};
			out_valid_q <= v_s[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= q_data.side;
			for (int k = 1; k < DEPTH; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	function automatic logic signed [lpc_pkg::POS_W-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [lpc_pkg::POS_W-1:0] r;
		if (v > SW'(32'sh7FFFFFFF)) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SW'(-33'sh80000000)) begin
			r = 32'sh80000000;
		end else begin
			r = v[lpc_pkg::POS_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		sum_x = SW'(sd.px) + SW'(rx[0]) + SW'(rx[1]) + SW'(rx[2]);
		sum_y = SW'(sd.py) + SW'(ry[0]) + SW'(ry[1]) + SW'(ry[2]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.matched <= sd.matched;
			out_q.out_x <= sd.matched ? sat(sum_x) : '0;
			out_q.out_y <= sd.matched ? sat(sum_y) : '0;
			out_q.out_heading <= sd.matched ? sd.heading : '0;
		end
	end

endmodule
